/* rtl/aus_pkg.sv */
`default_nettype none

package aus_pkg;

   // Fixed widths of the stream and result fields.
   localparam int DATA_BITS = 8;
   localparam int OUT_BITS  = 32;

   // NAL header decoding.
   localparam logic [4:0] NAL_TYPE_MASK = 5'h1f;
   localparam logic [4:0] NAL_NON_IDR   = 5'd1;
   localparam logic [4:0] NAL_IDR       = 5'd5;

   // Result queue: one input byte can produce at most two results.
   localparam int MAX_RESULTS   = 2;
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [OUT_BITS-1:0] unit_offset;
      logic [OUT_BITS-1:0] unit_length;
      logic                keyframe;
      logic                last_of_run;
   } result_type;

endpackage

`default_nettype wire

/* rtl/annexb_access_unit_splitter.sv */
`default_nettype none

// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    data_byte[7:0], last_byte
// rsp       out        rsp_valid/stall    unit_offset[31:0], unit_length[31:0],
//                                         keyframe, last_of_run
//
// One stream byte is taken per clock while req_stall is low. The parser state
// and the results of a byte are computed in the cycle of its transfer and land
// in a four-entry result queue, so a result can appear on rsp the cycle after
// the byte that caused it. A byte that closes one unit and flushes another
// queues two results; req_stall is raised whenever fewer than two queue entries are free.
// Reset is synchronous and active high; it clears the parser state and empties
// the queue. A stall on rsp only holds the queue head, and it blocks req only
// once three results are waiting in the queue.
module annexb_access_unit_splitter #(
   parameter int OFFSET_BITS = 32
) (
   input  wire  logic                          clock,
   input  wire  logic                          reset,

   input  wire  logic                          req_valid,
   output       logic                          req_stall,
   input  wire  logic [aus_pkg::DATA_BITS-1:0] req_data_byte,
   input  wire  logic                          req_last_byte,

   output       logic                          rsp_valid,
   input  wire  logic                          rsp_stall,
   output       logic [aus_pkg::OUT_BITS-1:0]  rsp_unit_offset,
   output       logic [aus_pkg::OUT_BITS-1:0]  rsp_unit_length,
   output       logic                          rsp_keyframe,
   output       logic                          rsp_last_of_run
);

   localparam logic [aus_pkg::FIFO_CNT_BITS-1:0] STALL_LEVEL =
      aus_pkg::FIFO_CNT_BITS'(aus_pkg::FIFO_DEPTH - aus_pkg::MAX_RESULTS);

   // Parser state.
   logic [OFFSET_BITS-1:0] byte_position_ff, byte_position_in;
   logic [1:0]             zero_run_ff, zero_run_in;
   logic                   expect_header_ff, expect_header_in;
   logic [OFFSET_BITS-1:0] code_start_ff, code_start_in;
   logic                   unit_open_ff, unit_open_in;
   logic                   unit_has_slice_ff, unit_has_slice_in;
   logic                   unit_has_idr_ff, unit_has_idr_in;
   logic [OFFSET_BITS-1:0] unit_start_ff, unit_start_in;
   logic                   pending_ff, pending_in;
   logic                   pending_idr_ff, pending_idr_in;

   // Result queue.
   aus_pkg::result_type                fifo_ff [aus_pkg::FIFO_DEPTH];
   logic [aus_pkg::FIFO_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [aus_pkg::FIFO_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [aus_pkg::FIFO_CNT_BITS-1:0]  fill_ff, fill_in;

   logic                   req_accept;
   logic                   rsp_accept;
   logic [4:0]             nal_type;
   logic                   nal_vcl;
   logic                   nal_idr;
   logic                   split_emit;
   logic                   last_emit;
   aus_pkg::result_type    split_result;
   aus_pkg::result_type    last_result;
   logic [aus_pkg::FIFO_PTR_BITS-1:0] second_ptr;

   // Saturates an offset or length to the 32-bit result field.
   function automatic logic [aus_pkg::OUT_BITS-1:0] clamp_out(
      input logic [OFFSET_BITS-1:0] value
   );
      logic [OFFSET_BITS+aus_pkg::OUT_BITS-1:0] wide;
      logic [OFFSET_BITS+aus_pkg::OUT_BITS-1:0] limit;
      wide  = {{aus_pkg::OUT_BITS{1'b0}}, value};
      limit = {{OFFSET_BITS{1'b0}}, {aus_pkg::OUT_BITS{1'b1}}};
      if (wide > limit) begin
         return {aus_pkg::OUT_BITS{1'b1}};
      end
      return wide[aus_pkg::OUT_BITS-1:0];
   endfunction

   // Length from start to stop, zero if the stop lies before the start.
   function automatic logic [aus_pkg::OUT_BITS-1:0] span_out(
      input logic [OFFSET_BITS-1:0] start,
      input logic [OFFSET_BITS-1:0] stop
   );
      logic [OFFSET_BITS-1:0] diff;
      diff = (stop >= start) ? (stop - start) : '0;
      return clamp_out(diff);
   endfunction

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign req_stall  = (fill_ff > STALL_LEVEL);

   assign nal_type = req_data_byte[4:0] & aus_pkg::NAL_TYPE_MASK;
   assign nal_vcl  = (nal_type == aus_pkg::NAL_NON_IDR) || (nal_type == aus_pkg::NAL_IDR);
   assign nal_idr  = (nal_type == aus_pkg::NAL_IDR);

   // Next parser state and the results caused by the byte on req.
   always_comb begin
      byte_position_in  = byte_position_ff;
      zero_run_in       = zero_run_ff;
      expect_header_in  = expect_header_ff;
      code_start_in     = code_start_ff;
      unit_open_in      = unit_open_ff;
      unit_has_slice_in = unit_has_slice_ff;
      unit_has_idr_in   = unit_has_idr_ff;
      unit_start_in     = unit_start_ff;
      pending_in        = pending_ff;
      pending_idr_in    = pending_idr_ff;
      split_emit        = 1'b0;

      if (expect_header_ff) begin
         // This byte is a NAL header and never counts toward a start code.
         expect_header_in = 1'b0;
         zero_run_in      = 2'd0;
         if (unit_open_ff && unit_has_slice_ff && nal_vcl && !req_last_byte) begin
            // A further slice: the split depends on its first payload bit.
            pending_in     = 1'b1;
            pending_idr_in = nal_idr;
         end else begin
            if (!unit_open_ff || unit_has_slice_ff) begin
               split_emit        = unit_open_ff && unit_has_slice_ff;
               unit_open_in      = 1'b1;
               unit_start_in     = code_start_ff;
               unit_has_slice_in = 1'b0;
               unit_has_idr_in   = 1'b0;
            end
            if (nal_vcl) begin
               unit_has_slice_in = 1'b1;
            end
            if (nal_idr) begin
               unit_has_idr_in = 1'b1;
            end
         end
      end else begin
         if (pending_ff) begin
            // First payload bit set means the slice starts at macroblock zero.
            if (req_data_byte[aus_pkg::DATA_BITS-1]) begin
               split_emit      = unit_open_ff && unit_has_slice_ff;
               unit_open_in    = 1'b1;
               unit_start_in   = code_start_ff;
               unit_has_idr_in = 1'b0;
            end
            unit_has_slice_in = 1'b1;
            if (pending_idr_ff) begin
               unit_has_idr_in = 1'b1;
            end
            pending_in     = 1'b0;
            pending_idr_in = 1'b0;
         end
         if (req_data_byte == '0) begin
            if (zero_run_ff != 2'd3) begin
               zero_run_in = zero_run_ff + 2'd1;
            end
         end else if (req_data_byte == aus_pkg::DATA_BITS'(1) && zero_run_ff >= 2'd2) begin
            code_start_in    = byte_position_ff - OFFSET_BITS'(zero_run_ff);
            expect_header_in = 1'b1;
            zero_run_in      = 2'd0;
         end else begin
            zero_run_in = 2'd0;
         end
      end

      if (byte_position_ff != '1) begin
         byte_position_in = byte_position_ff + OFFSET_BITS'(1);
      end

      last_emit = req_last_byte && unit_open_in && unit_has_slice_in;

      split_result.unit_offset = clamp_out(unit_start_ff);
      split_result.unit_length = span_out(unit_start_ff, code_start_ff);
      split_result.keyframe    = unit_has_idr_ff;
      split_result.last_of_run = !last_emit;

      last_result.unit_offset = clamp_out(unit_start_in);
      last_result.unit_length = span_out(unit_start_in, byte_position_in);
      last_result.keyframe    = unit_has_idr_in;
      last_result.last_of_run = 1'b1;

      if (req_last_byte) begin
         // The stream ends here; the next byte starts a new one at offset zero.
         byte_position_in  = '0;
         zero_run_in       = 2'd0;
         expect_header_in  = 1'b0;
         code_start_in     = '0;
         unit_open_in      = 1'b0;
         unit_has_slice_in = 1'b0;
         unit_has_idr_in   = 1'b0;
         unit_start_in     = '0;
         pending_in        = 1'b0;
         pending_idr_in    = 1'b0;
      end
   end

   // Queue bookkeeping.
   always_comb begin
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      fill_in    = fill_ff;
      second_ptr = wr_ptr_ff + aus_pkg::FIFO_PTR_BITS'(split_emit);
      if (req_accept) begin
         wr_ptr_in = wr_ptr_ff + aus_pkg::FIFO_PTR_BITS'(split_emit)
                   + aus_pkg::FIFO_PTR_BITS'(last_emit);
         fill_in   = fill_ff + aus_pkg::FIFO_CNT_BITS'(split_emit)
                   + aus_pkg::FIFO_CNT_BITS'(last_emit);
      end
      if (rsp_accept) begin
         rd_ptr_in = rd_ptr_ff + aus_pkg::FIFO_PTR_BITS'(1);
         fill_in   = fill_in - aus_pkg::FIFO_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff  <= '0;
         zero_run_ff       <= 2'd0;
         expect_header_ff  <= 1'b0;
         code_start_ff     <= '0;
         unit_open_ff      <= 1'b0;
         unit_has_slice_ff <= 1'b0;
         unit_has_idr_ff   <= 1'b0;
         unit_start_ff     <= '0;
         pending_ff        <= 1'b0;
         pending_idr_ff    <= 1'b0;
         wr_ptr_ff         <= '0;
         rd_ptr_ff         <= '0;
         fill_ff           <= '0;
      end else begin
         if (req_accept) begin
            byte_position_ff  <= byte_position_in;
            zero_run_ff       <= zero_run_in;
            expect_header_ff  <= expect_header_in;
            code_start_ff     <= code_start_in;
            unit_open_ff      <= unit_open_in;
            unit_has_slice_ff <= unit_has_slice_in;
            unit_has_idr_ff   <= unit_has_idr_in;
            unit_start_ff     <= unit_start_in;
            pending_ff        <= pending_in;
            pending_idr_ff    <= pending_idr_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage; the closed unit goes in ahead of the flushed one.
   always_ff @(posedge clock) begin
      if (req_accept && split_emit) begin
         fifo_ff[wr_ptr_ff] <= split_result;
      end
      if (req_accept && last_emit) begin
         fifo_ff[second_ptr] <= last_result;
      end
   end

   assign rsp_valid       = (fill_ff != '0);
   assign rsp_unit_offset = fifo_ff[rd_ptr_ff].unit_offset;
   assign rsp_unit_length = fifo_ff[rd_ptr_ff].unit_length;
   assign rsp_keyframe    = fifo_ff[rd_ptr_ff].keyframe;
   assign rsp_last_of_run = fifo_ff[rd_ptr_ff].last_of_run;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= aus_pkg::FIFO_CNT_BITS'(aus_pkg::FIFO_DEPTH))
      else $error("result queue overfilled");

   a_pending_in_slice_unit: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> (unit_open_ff && unit_has_slice_ff))
      else $error("slice decision pending outside a unit holding a slice");

   a_pending_not_header: assert property (@(posedge clock) disable iff (reset)
      !(pending_ff && expect_header_ff))
      else $error("slice decision pending while a header is expected");

   a_header_zero_run: assert property (@(posedge clock) disable iff (reset)
      expect_header_ff |-> (zero_run_ff == 2'd0))
      else $error("zero run not cleared at a start code");

   a_last_flushes: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_last_byte) |=> (!unit_open_ff && byte_position_ff == '0))
      else $error("stream end did not return the parser to its start");
`endif

endmodule

`default_nettype wire
